### design/gbsa_pkg.sv
package gbsa_pkg;

    localparam int ADDR_W   = 24;
    localparam int OSIZE_W  = 16;
    localparam int ASZ_W    = 17;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [ADDR_W-1:0] ADDR_MAX = 24'hFFFFFF;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PRUNE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   alloc_address;
    } resp_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
    } alu_ctrl_t;

endpackage

### design/growing_bitmap_slot_allocator.sv
// Slot allocator over a chain of up to MAX_POOLS pools with occupancy bitmasks. One request
// is worked at a time; s_ready is high only while the sequencer is idle. An alloc scans the
// pools and then forms the slot address, a free divides the address and then scans the pools;
// SLOT_W is the global slot number width (9 bits by default). One shared adder/subtractor
// forms the slot address one multiplier bit per cycle and divides the freed address one
// quotient bit per cycle, and the pool scan checks one pool per cycle. A finished result
// waits in the output register while the next request is taken.
module growing_bitmap_slot_allocator
    import gbsa_pkg::*;
#(
    parameter int MAX_POOLS        = 8,
    parameter int POOL_SLOTS_MAX   = 32,
    parameter int FIRST_POOL_SLOTS = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [OSIZE_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  req_t               s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output resp_t              m_item
);

    localparam int FIRST_SLOTS = (FIRST_POOL_SLOTS > POOL_SLOTS_MAX) ? POOL_SLOTS_MAX
                                                                    : FIRST_POOL_SLOTS;
    localparam int POOL_W = $clog2(MAX_POOLS + 1);
    localparam int IDX_W  = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
    localparam int NS_W   = $clog2(POOL_SLOTS_MAX + 1);
    localparam int MIDX_W = $clog2(POOL_SLOTS_MAX);
    localparam int SLOT_W = $clog2(MAX_POOLS * POOL_SLOTS_MAX + 1);
    localparam int AW     = (SLOT_W + ASZ_W > ADDR_W) ? SLOT_W + ASZ_W : ADDR_W + 1;
    localparam int CNT_W  = $clog2(ADDR_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_COMMIT,
        ST_DIV,
        ST_DIVCHK,
        ST_FINISH
    } state_t;

    function automatic logic [ASZ_W-1:0] round4(input logic [OSIZE_W-1:0] s);
        logic [ASZ_W-1:0] t;
        t = {1'b0, s} + ASZ_W'(3);
        return {t[ASZ_W-1:2], 2'b00};
    endfunction

    function automatic logic [POOL_SLOTS_MAX-1:0] avail_mask(input logic [NS_W-1:0] n);
        logic [POOL_SLOTS_MAX-1:0] m;
        for (int i = 0; i < POOL_SLOTS_MAX; i++) begin
            m[i] = (NS_W'(i) < n);
        end
        return m;
    endfunction

    function automatic logic [MIDX_W-1:0] lowest_bit(input logic [POOL_SLOTS_MAX-1:0] m);
        logic [MIDX_W-1:0] b;
        b = '0;
        for (int i = POOL_SLOTS_MAX - 1; i >= 0; i--) begin
            if (m[i]) begin
                b = MIDX_W'(i);
            end
        end
        return b;
    endfunction

    state_t                    state_reg, state_next;
    logic [OSIZE_W-1:0]        object_size_reg, object_size_next;
    logic [OSIZE_W-1:0]        pool_size_reg, pool_size_next;
    logic [POOL_W-1:0]         open_pools_reg, open_pools_next;
    logic [POOL_SLOTS_MAX-1:0] masks_reg [MAX_POOLS];
    logic [POOL_SLOTS_MAX-1:0] masks_next [MAX_POOLS];
    logic                      is_free_reg, is_free_next;
    logic                      new_pool_reg, new_pool_next;
    logic [POOL_W-1:0]         idx_reg, idx_next;
    logic [SLOT_W-1:0]         base_reg, base_next;
    logic [NS_W-1:0]           nslots_reg, nslots_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [MIDX_W-1:0]         bit_reg, bit_next;
    logic [ASZ_W-1:0]          asz_reg, asz_next;
    logic [AW-1:0]             acc_reg, acc_next;
    logic [ADDR_W-1:0]         quo_reg, quo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    resp_t                     res_reg, res_next;
    logic                      m_valid_reg, m_valid_next;
    resp_t                     m_item_reg, m_item_next;

    logic [IDX_W-1:0]          idx_sel, open_sel;
    logic [POOL_SLOTS_MAX-1:0] free_bits;
    logic [MIDX_W-1:0]         low_bit;
    logic [SLOT_W-1:0]         base_end;
    logic [NS_W:0]             nslots_dbl;
    logic [NS_W-1:0]           nslots_step;
    logic [ADDR_W-1:0]         free_off;
    logic [AW-1:0]             mul_a, mul_b, div_a, alu_a, alu_b, alu_res;
    logic                      alu_borrow;
    alu_ctrl_t                 alu_ctrl;

    assign idx_sel     = idx_reg[IDX_W-1:0];
    assign open_sel    = open_pools_reg[IDX_W-1:0];
    assign free_bits   = avail_mask(nslots_reg) & ~masks_reg[idx_sel];
    assign low_bit     = lowest_bit(free_bits);
    assign base_end    = base_reg + SLOT_W'(nslots_reg);
    assign nslots_dbl  = {nslots_reg, 1'b0};
    assign nslots_step = (nslots_dbl > (NS_W + 1)'(POOL_SLOTS_MAX)) ? NS_W'(POOL_SLOTS_MAX)
                                                                    : nslots_dbl[NS_W-1:0];
    assign free_off    = quo_reg - ADDR_W'(base_reg);

    assign mul_a = {acc_reg[AW-2:0], 1'b0};
    assign mul_b = slot_reg[SLOT_W-1] ? AW'(asz_reg) : '0;
    assign div_a = {acc_reg[AW-2:0], quo_reg[ADDR_W-1]};

    always_comb begin
        if (state_reg == ST_DIV) begin
            alu_a       = div_a;
            alu_b       = AW'(asz_reg);
            alu_ctrl.op = ALU_SUB;
        end else begin
            alu_a       = mul_a;
            alu_b       = mul_b;
            alu_ctrl.op = ALU_ADD;
        end
    end

    gbsa_alu #(
        .W(AW)
    ) u_alu (
        .op_a  (alu_a),
        .op_b  (alu_b),
        .ctrl  (alu_ctrl),
        .result(alu_res),
        .borrow(alu_borrow)
    );

    always_comb begin
        state_next       = state_reg;
        object_size_next = object_size_reg;
        pool_size_next   = pool_size_reg;
        open_pools_next  = open_pools_reg;
        masks_next       = masks_reg;
        is_free_next     = is_free_reg;
        new_pool_next    = new_pool_reg;
        idx_next         = idx_reg;
        base_next        = base_reg;
        nslots_next      = nslots_reg;
        slot_next        = slot_reg;
        bit_next         = bit_reg;
        asz_next         = asz_reg;
        acc_next         = acc_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        res_next         = res_reg;
        m_valid_next     = m_valid_reg;
        m_item_next      = m_item_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_wr_en) begin
            object_size_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_next.status        = STATUS_OK;
                    res_next.alloc_address = '0;
                    unique case (s_item.func)
                        FUNC_ALLOC: begin
                            if (object_size_reg == '0 ||
                                (open_pools_reg != '0 && object_size_reg != pool_size_reg)) begin
                                res_next.status = STATUS_NO_SLOT;
                                state_next      = ST_FINISH;
                            end else begin
                                asz_next     = round4(object_size_reg);
                                idx_next     = '0;
                                base_next    = '0;
                                nslots_next  = NS_W'(FIRST_SLOTS);
                                is_free_next = 1'b0;
                                state_next   = ST_SCAN;
                            end
                        end
                        FUNC_FREE: begin
                            if (open_pools_reg == '0 || pool_size_reg == '0) begin
                                res_next.status = STATUS_INVALID;
                                state_next      = ST_FINISH;
                            end else begin
                                asz_next     = round4(pool_size_reg);
                                quo_next     = s_item.address;
                                acc_next     = '0;
                                cnt_next     = CNT_W'(ADDR_W);
                                is_free_next = 1'b1;
                                state_next   = ST_DIV;
                            end
                        end
                        FUNC_PRUNE: begin
                            open_pools_next = '0;
                            for (int i = 0; i < MAX_POOLS; i++) begin
                                masks_next[i] = '0;
                            end
                            state_next = ST_FINISH;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (idx_reg == open_pools_reg) begin
                    if (is_free_reg) begin
                        res_next.status = STATUS_INVALID;
                        state_next      = ST_FINISH;
                    end else if (open_pools_reg >= POOL_W'(MAX_POOLS)) begin
                        res_next.status = STATUS_NO_SLOT;
                        state_next      = ST_FINISH;
                    end else begin
                        slot_next     = base_reg;
                        new_pool_next = 1'b1;
                        acc_next      = '0;
                        cnt_next      = CNT_W'(SLOT_W);
                        state_next    = ST_MUL;
                    end
                end else if (is_free_reg && quo_reg < ADDR_W'(base_end)) begin
                    masks_next[idx_sel][free_off[MIDX_W-1:0]] = 1'b0;
                    state_next = ST_FINISH;
                end else if (!is_free_reg && free_bits != '0) begin
                    slot_next     = base_reg + SLOT_W'(low_bit);
                    bit_next      = low_bit;
                    new_pool_next = 1'b0;
                    acc_next      = '0;
                    cnt_next      = CNT_W'(SLOT_W);
                    state_next    = ST_MUL;
                end else begin
                    idx_next    = idx_reg + POOL_W'(1);
                    base_next   = base_end;
                    nslots_next = nslots_step;
                end
            end
            ST_MUL: begin
                acc_next  = alu_res;
                slot_next = {slot_reg[SLOT_W-2:0], 1'b0};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (acc_reg > AW'(ADDR_MAX)) begin
                    res_next.status = STATUS_NO_SLOT;
                end else begin
                    res_next.alloc_address = acc_reg[ADDR_W-1:0];
                    if (new_pool_reg) begin
                        masks_next[open_sel] = POOL_SLOTS_MAX'(1);
                        open_pools_next      = open_pools_reg + POOL_W'(1);
                        if (open_pools_reg == '0) begin
                            pool_size_next = object_size_reg;
                        end
                    end else begin
                        masks_next[idx_sel][bit_reg] = 1'b1;
                    end
                end
                state_next = ST_FINISH;
            end
            ST_DIV: begin
                acc_next = alu_borrow ? div_a : alu_res;
                quo_next = {quo_reg[ADDR_W-2:0], ~alu_borrow};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_DIVCHK;
                end
            end
            ST_DIVCHK: begin
                if (acc_reg != '0) begin
                    res_next.status = STATUS_INVALID;
                    state_next      = ST_FINISH;
                end else begin
                    idx_next    = '0;
                    base_next   = '0;
                    nslots_next = NS_W'(FIRST_SLOTS);
                    state_next  = ST_SCAN;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            object_size_reg <= '0;
            pool_size_reg   <= '0;
            open_pools_reg  <= '0;
            for (int i = 0; i < MAX_POOLS; i++) begin
                masks_reg[i] <= '0;
            end
            is_free_reg     <= 1'b0;
            new_pool_reg    <= 1'b0;
            idx_reg         <= '0;
            base_reg        <= '0;
            nslots_reg      <= '0;
            slot_reg        <= '0;
            bit_reg         <= '0;
            asz_reg         <= '0;
            acc_reg         <= '0;
            quo_reg         <= '0;
            cnt_reg         <= '0;
            res_reg         <= '0;
            m_valid_reg     <= 1'b0;
            m_item_reg      <= '0;
        end else begin
            state_reg       <= state_next;
            object_size_reg <= object_size_next;
            pool_size_reg   <= pool_size_next;
            open_pools_reg  <= open_pools_next;
            masks_reg       <= masks_next;
            is_free_reg     <= is_free_next;
            new_pool_reg    <= new_pool_next;
            idx_reg         <= idx_next;
            base_reg        <= base_next;
            nslots_reg      <= nslots_next;
            slot_reg        <= slot_next;
            bit_reg         <= bit_next;
            asz_reg         <= asz_next;
            acc_reg         <= acc_next;
            quo_reg         <= quo_next;
            cnt_reg         <= cnt_next;
            res_reg         <= res_next;
            m_valid_reg     <= m_valid_next;
            m_item_reg      <= m_item_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        open_pools_reg <= POOL_W'(MAX_POOLS))
        else $error("open pool count beyond limit");

    a_prune_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.func == FUNC_PRUNE) |=> (open_pools_reg == '0))
        else $error("prune left pools open");

    a_addr_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.alloc_address[1:0] == 2'b00))
        else $error("allocated address not word aligned");

    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status != STATUS_OK) |-> (m_item.alloc_address == '0))
        else $error("failed request carries an address");

endmodule

### design/gbsa_alu.sv
module gbsa_alu
    import gbsa_pkg::*;
#(
    parameter int W = 27
) (
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    input  alu_ctrl_t    ctrl,
    output logic [W-1:0] result,
    output logic         borrow
);

    logic [W:0] full;

    always_comb begin
        unique case (ctrl.op)
            ALU_ADD: full = {1'b0, op_a} + {1'b0, op_b};
            ALU_SUB: full = {1'b0, op_a} - {1'b0, op_b};
            default: full = '0;
        endcase
    end

    assign result = full[W-1:0];
    assign borrow = full[W];

endmodule
